// ===== sv/assert_macros.svh =====
// Assertion helpers used by the sequencer core.
// All checks are sampled on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Byte framing
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = 4;
  localparam logic [BIT_CNT_W-1:0] BIT_CNT_BYTE = BIT_CNT_W'(BITS_PER_BYTE);

  // Field widths
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned POLL_W  = 8;
  localparam int unsigned BYTE_W  = 8;

  // Register reset values
  localparam logic [TIMER_W-1:0] HALF_PERIOD_RST = 16'd3;
  localparam logic [POLL_W-1:0]  ACK_TIMEOUT_RST = 8'd80;

  // Command codes
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6,
    OP_WAIT  = 3'd7
  } op_e;

  // Step within a command sequence
  typedef enum logic [2:0] {
    STEP_0 = 3'd0,
    STEP_1 = 3'd1,
    STEP_2 = 3'd2,
    STEP_3 = 3'd3,
    STEP_4 = 3'd4
  } step_e;

  // Completion status
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_START_FAIL = 2'd1,
    ST_NO_ACK     = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } cfg_reg_e;

  // Result item, lowest field in the lowest bits
  typedef struct packed {
    logic              cmd_ignored;
    logic [1:0]        status;
    logic [BYTE_W-1:0] rx_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl_out;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// I2C master bit sequencer, driven one tick per input transaction.
// Input stream: each transaction is one bus tick carrying a command opcode,
// the byte for a write, and the sampled SDA level. A nonzero opcode starts a
// command only while the sequencer is idle; otherwise it is dropped and the
// matching result flags cmd_ignored.
// Output stream: exactly one result per input transaction with the SCL/SDA
// drive levels, busy, a done pulse, the last byte read and a status code.
// Configuration channel: index 0 sets half_period (ticks per phase), index 1
// sets ack_timeout (high polls that end the wait with no ack). Write only
// while idle; the channel is always ready.
// The result of a transaction sits in the output register on the
// next cycle. Throughput: one transaction per cycle while the output is not stalled, set by the single
// sequencer update between the state registers and the output register.
// A transaction is taken while the output register is empty or being read,
// so a stalled receiver stalls the input after one buffered result.
// Reset: both lines released, sequencer idle, status ok, rx_byte zero,
// half_period 3, ack_timeout 80, output register empty.

`include "assert_macros.svh"

module i2c_master_bit_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: opcode[2:0], tx_byte[10:3], sda_in[11], zero pad[15:12]
  input  wire logic [15:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
  //        status[13:12], cmd_ignored[14], zero pad[15]
  output logic [15:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [i2cm_pkg::TIMER_W-1:0] half_period_q;
  logic [i2cm_pkg::POLL_W-1:0]  ack_timeout_q;

  // Sequencer state
  i2cm_pkg::op_e                  cmd_q, cmd_d;
  i2cm_pkg::step_e                step_q, step_d;
  logic [i2cm_pkg::TIMER_W-1:0]   timer_q, timer_d;
  logic [i2cm_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [i2cm_pkg::BYTE_W-1:0]    shift_q, shift_d;
  logic [i2cm_pkg::POLL_W-1:0]    poll_q, poll_d;
  logic                           scl_q, scl_d;
  logic                           sda_q, sda_d;
  i2cm_pkg::status_e              status_q, status_d;
  logic [i2cm_pkg::BYTE_W-1:0]    rx_q, rx_d;

  // Output register
  i2cm_pkg::result_t res_q, res_d;
  logic              m_valid_q;

  // Per-transaction scratch
  i2cm_pkg::op_e                 op_in;
  logic [i2cm_pkg::BYTE_W-1:0]   tx_in;
  logic                          sda_in;
  logic                          in_accept;
  logic                          run;
  logic                          done;
  logic                          ignored;
  logic [i2cm_pkg::TIMER_W-1:0]  hold_ticks;
  logic [i2cm_pkg::POLL_W-1:0]   poll_limit;

  // Unpack input fields
  assign op_in  = i2cm_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign tx_in  = s_axis_tdata_i[10:3];
  assign sda_in = s_axis_tdata_i[11];

  // Take a tick while the output register is free or being drained
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q};
  assign cfg_ready_o     = 1'b1;

  // Zero settings behave as one
  assign hold_ticks = (half_period_q == '0) ? i2cm_pkg::TIMER_W'(1) : half_period_q;
  assign poll_limit = (ack_timeout_q == '0) ? i2cm_pkg::POLL_W'(1) : ack_timeout_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cm_pkg::HALF_PERIOD_RST;
      ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (i2cm_pkg::cfg_reg_e'(cfg_addr_i))
        i2cm_pkg::REG_HALF_PERIOD: half_period_q <= cfg_data_i;
        i2cm_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[i2cm_pkg::POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state: launch or time the current step, then advance the sequence
  always_comb begin
    cmd_d     = cmd_q;
    step_d    = step_q;
    timer_d   = timer_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    status_d  = status_q;
    rx_d      = rx_q;
    run       = 1'b0;
    done      = 1'b0;
    ignored   = 1'b0;

    if (cmd_q == i2cm_pkg::OP_NONE) begin
      if (op_in != i2cm_pkg::OP_NONE) begin
        cmd_d    = op_in;
        step_d   = i2cm_pkg::STEP_0;
        status_d = i2cm_pkg::ST_OK;
        if (op_in == i2cm_pkg::OP_WRITE) begin
          shift_d = tx_in;
        end
        run = 1'b1;
      end
    end else begin
      ignored = (op_in != i2cm_pkg::OP_NONE);
      if (cmd_q == i2cm_pkg::OP_WAIT && step_q == i2cm_pkg::STEP_3 && timer_q == '0) begin
        // Ack polling runs on every tick once the hold has expired
        run = 1'b1;
      end else begin
        timer_d = (timer_q != '0) ? timer_q - i2cm_pkg::TIMER_W'(1) : '0;
        run     = (timer_d == '0);
      end
    end

    if (run) begin
      unique case (cmd_d)
        i2cm_pkg::OP_START: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            scl_d = 1'b1; sda_d = 1'b1;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            if (!sda_in) begin
              status_d = i2cm_pkg::ST_START_FAIL;
              cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
            end else begin
              sda_d = 1'b0;
              step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
            end
          end else begin
            if (sda_in) begin
              status_d = i2cm_pkg::ST_START_FAIL;
            end else begin
              scl_d = 1'b0;
            end
            cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
          end
        end
        i2cm_pkg::OP_STOP: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            scl_d = 1'b0; sda_d = 1'b0;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            scl_d = 1'b1;
            step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
          end else begin
            sda_d = 1'b1;
            cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
          end
        end
        i2cm_pkg::OP_ACK: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            sda_d = 1'b0;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            scl_d = 1'b1;
            step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_2) begin
            scl_d = 1'b0;
            step_d = i2cm_pkg::STEP_3; timer_d = hold_ticks;
          end else begin
            sda_d = 1'b1;
            cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
          end
        end
        i2cm_pkg::OP_NACK: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            scl_d = 1'b0; sda_d = 1'b1;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            scl_d = 1'b1;
            step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
          end else begin
            scl_d = 1'b0;
            cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
          end
        end
        i2cm_pkg::OP_WAIT: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            scl_d = 1'b0;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            sda_d = 1'b1;
            step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_2) begin
            scl_d = 1'b1; poll_d = '0;
            step_d = i2cm_pkg::STEP_3; timer_d = hold_ticks;
          end else begin
            timer_d = '0;
            if (!sda_in) begin
              scl_d = 1'b0;
              cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; done = 1'b1;
            end else begin
              poll_d = poll_q + i2cm_pkg::POLL_W'(1);
              if (poll_d >= poll_limit) begin
                // Timed out: report no ack and enter the first step of a stop
                status_d = i2cm_pkg::ST_NO_ACK;
                cmd_d = i2cm_pkg::OP_STOP;
                scl_d = 1'b0; sda_d = 1'b0;
                step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
              end
            end
          end
        end
        i2cm_pkg::OP_WRITE: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            scl_d = 1'b0; bit_cnt_d = '0;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            if (bit_cnt_d >= i2cm_pkg::BIT_CNT_BYTE) begin
              cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
            end else begin
              sda_d   = shift_d[i2cm_pkg::BYTE_W-1];
              shift_d = {shift_d[i2cm_pkg::BYTE_W-2:0], 1'b0};
              step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
            end
          end else if (step_d == i2cm_pkg::STEP_2) begin
            scl_d = 1'b1;
            step_d = i2cm_pkg::STEP_3; timer_d = hold_ticks;
          end else begin
            scl_d = 1'b0;
            bit_cnt_d = bit_cnt_q + i2cm_pkg::BIT_CNT_W'(1);
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end
        end
        i2cm_pkg::OP_READ: begin
          if (step_d == i2cm_pkg::STEP_0) begin
            sda_d = 1'b1; bit_cnt_d = '0; shift_d = '0;
            step_d = i2cm_pkg::STEP_1; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_1) begin
            shift_d = {shift_q[i2cm_pkg::BYTE_W-2:0], 1'b0};
            scl_d = 1'b0;
            step_d = i2cm_pkg::STEP_2; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_2) begin
            scl_d = 1'b1;
            step_d = i2cm_pkg::STEP_3; timer_d = hold_ticks;
          end else if (step_d == i2cm_pkg::STEP_3) begin
            // Sample SDA into the low bit, then make room for the next bit unless the byte is complete
            shift_d   = {shift_q[i2cm_pkg::BYTE_W-1:1], shift_q[0] | sda_in};
            bit_cnt_d = bit_cnt_q + i2cm_pkg::BIT_CNT_W'(1);
            scl_d = 1'b0;
            timer_d = hold_ticks;
            if (bit_cnt_d < i2cm_pkg::BIT_CNT_BYTE) begin
              shift_d = {shift_d[i2cm_pkg::BYTE_W-2:0], 1'b0};
              step_d = i2cm_pkg::STEP_2;
            end else begin
              step_d = i2cm_pkg::STEP_4;
            end
          end else begin
            rx_d = shift_q;
            cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
          end
        end
        default: begin
          cmd_d = i2cm_pkg::OP_NONE; step_d = i2cm_pkg::STEP_0; timer_d = '0; done = 1'b1;
        end
      endcase
    end
  end

  // Outputs: assemble the result of this tick
  always_comb begin
    res_d.scl_out     = scl_d;
    res_d.sda_out     = sda_d;
    res_d.busy_res    = (cmd_d != i2cm_pkg::OP_NONE);
    res_d.done_res    = done;
    res_d.rx_byte     = rx_d;
    res_d.status      = status_d;
    res_d.cmd_ignored = ignored;
  end

  // Advance sequencer state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= i2cm_pkg::OP_NONE;
      step_q    <= i2cm_pkg::STEP_0;
      timer_q   <= '0;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      poll_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      status_q  <= i2cm_pkg::ST_OK;
      rx_q      <= '0;
    end else if (in_accept) begin
      cmd_q     <= cmd_d;
      step_q    <= step_d;
      timer_q   <= timer_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      poll_q    <= poll_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      status_q  <= status_d;
      rx_q      <= rx_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  `CHECK_ALWAYS(a_idle_clean,
    (cmd_q != i2cm_pkg::OP_NONE) || (timer_q == '0 && step_q == i2cm_pkg::STEP_0),
    "idle sequencer has a running timer or step")
  `CHECK_ALWAYS(a_no_overwrite,
    !(m_valid_q && !m_axis_tready_i && in_accept),
    "result register overwritten while stalled")
  `CHECK_NEXT(a_busy_drop,
    in_accept && cmd_q != i2cm_pkg::OP_NONE && op_in != i2cm_pkg::OP_NONE,
    m_valid_q && res_q.cmd_ignored,
    "command during busy not flagged as ignored")
  `CHECK_NEXT(a_status_hold, !in_accept, $stable(status_q),
    "status changed without a transaction")

endmodule

`default_nettype wire
